// File: rtl/nnis_pkg.sv
// shared constants, types and helpers for the nearest neighbor scaler
`default_nettype none

package nnis_pkg;

    localparam int unsigned DIM_MAX      = 256;
    localparam int unsigned FRAME_PIXELS = 65536;
    localparam int unsigned PIX_W        = 32;
    localparam int unsigned CFG_W        = 9;
    localparam int unsigned CFG_REGS     = 4;
    localparam int unsigned CFG_RESET    = 256;
    localparam int unsigned CFG_IDX_W    = $clog2(CFG_REGS);
    localparam int unsigned ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int unsigned POS_W        = $clog2(DIM_MAX);
    localparam int unsigned NUM_W        = 2 * POS_W;
    localparam int unsigned STEP_W       = $clog2(NUM_W);

    typedef logic [CFG_W-1:0] dim_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_FETCH = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ,
        S_PUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // zero acts as one, anything above the maximum saturates
    function automatic dim_t dim_of(input dim_t value);
        dim_t result;
        if (value == dim_t'(0))
            result = dim_t'(1);
        else if (value > dim_t'(DIM_MAX))
            result = dim_t'(DIM_MAX);
        else
            result = value;
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nnis_if.sv
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface nnis_req_if;
    import nnis_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [PIX_W-1:0]     pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface nnis_rsp_if;
    import nnis_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic                 last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

interface nnis_cfg_if;
    import nnis_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nnis_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module nnis_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nnis_pkg::NUM_W-1:0]  num,
    input  nnis_pkg::dim_t              den,
    output logic [nnis_pkg::NUM_W-1:0]  quo,
    output nnis_pkg::div_stat_t         stat
);
    import nnis_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  rem_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [CFG_W:0]    trial;
    logic [CFG_W:0]    diff;
    logic              ge;

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/nearest_neighbor_image_scaler_unit.sv
// nearest neighbor scaler: frame store, coordinate dividers and output stage
//
// Channels: cfg writes one of four size registers (src_width, src_height,
// dst_width, dst_height) and is always ready; write only while no fetch is
// in flight. req carries one transaction per request: req_type 0 stores
// pixel_in at the next raster position of the source frame, req_type 1
// fetches the next output pixel. rsp returns one transaction per fetch with
// pixel_out and last_pixel, set on the final pixel of the output frame.
// A load is written as it is accepted and the next request can follow at
// once. A fetch passes through the bit-serial dividers for both source
// coordinates, a step to act on their done flag, then the store address,
// the store read and the output register before rsp.valid. Requests are
// taken one at a time, so no request is accepted while a fetch is still
// in these steps; req.ready is high again once a fetch has reached the
// output register, even while that result waits on a stalled receiver. A
// following fetch then holds in its last step until the output frees.
// Reset clears the load and output counters and sets all sizes to 256; the
// frame store is not cleared, so fetch only pixels that were loaded.
`default_nettype none

module nearest_neighbor_image_scaler_unit (
    input  logic        clk,
    input  logic        rst_n,
    nnis_cfg_if.sink    cfg,
    nnis_req_if.sink    req,
    nnis_rsp_if.source  rsp
);
    import nnis_pkg::*;

    localparam int unsigned TOT_W   = 2 * CFG_W;
    localparam int unsigned PROD_W  = POS_W + CFG_W;
    localparam int unsigned DIV_LAT = NUM_W + 1;

    state_t            state_reg;
    state_t            state_next;
    dim_t              src_width_reg;
    dim_t              src_height_reg;
    dim_t              dst_width_reg;
    dim_t              dst_height_reg;
    logic [ADDR_W-1:0] load_index_reg;
    logic [ADDR_W-1:0] load_index_next;
    logic [POS_W-1:0]  out_col_reg;
    logic [POS_W-1:0]  out_col_next;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_row_next;
    logic              last_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  rd_data_reg;
    logic [PIX_W-1:0]  pixel_out_reg;
    logic [PIX_W-1:0]  pixel_out_next;
    logic              last_out_reg;
    logic              last_out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [PIX_W-1:0]  mem [FRAME_PIXELS];

    dim_t              sw;
    dim_t              sh;
    dim_t              dw;
    dim_t              dh;
    logic              req_fire;
    logic              load_fire;
    logic              fetch_fire;
    logic              rd_en;
    logic [TOT_W-1:0]  load_total;
    logic [TOT_W-1:0]  load_succ;
    dim_t              col_succ;
    dim_t              row_succ;
    logic              col_end;
    logic              row_end;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [PROD_W-1:0] prod_a;
    logic [NUM_W-1:0]  qx;
    logic [NUM_W-1:0]  qy;
    logic [POS_W-1:0]  sx;
    logic [POS_W-1:0]  sy;
    div_stat_t         div_x_stat;
    div_stat_t         div_y_stat;

    assign sw = dim_of(src_width_reg);
    assign sh = dim_of(src_height_reg);
    assign dw = dim_of(dst_width_reg);
    assign dh = dim_of(dst_height_reg);

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign req_fire   = req.valid && req.ready;
    assign load_fire  = req_fire && (req.req_type == REQ_LOAD);
    assign fetch_fire = req_fire && (req.req_type == REQ_FETCH);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= dim_t'(CFG_RESET);
            src_height_reg <= dim_t'(CFG_RESET);
            dst_width_reg  <= dim_t'(CFG_RESET);
            dst_height_reg <= dim_t'(CFG_RESET);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_SRC_WIDTH:  src_width_reg  <= cfg.data;
                REG_SRC_HEIGHT: src_height_reg <= cfg.data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg.data;
                REG_DST_HEIGHT: dst_height_reg <= cfg.data;
            endcase
        end
    end

    // load counter wraps at the end of the source frame
    assign load_total      = TOT_W'(sw) * TOT_W'(sh);
    assign load_succ       = TOT_W'(load_index_reg) + TOT_W'(1);
    assign load_index_next = (load_succ >= load_total) ? '0 : load_succ[ADDR_W-1:0];

    // output raster position
    assign col_succ     = dim_t'(out_col_reg) + dim_t'(1);
    assign row_succ     = dim_t'(out_row_reg) + dim_t'(1);
    assign col_end      = col_succ >= dw;
    assign row_end      = row_succ >= dh;
    assign out_col_next = col_end ? '0 : col_succ[POS_W-1:0];
    assign out_row_next = col_end ? (row_end ? '0 : row_succ[POS_W-1:0]) : out_row_reg;

    assign prod_x = PROD_W'(out_col_reg) * PROD_W'(sw);
    assign prod_y = PROD_W'(out_row_reg) * PROD_W'(sh);

    nnis_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fetch_fire),
        .num   (prod_x[NUM_W-1:0]),
        .den   (dw),
        .quo   (qx),
        .stat  (div_x_stat)
    );

    nnis_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fetch_fire),
        .num   (prod_y[NUM_W-1:0]),
        .den   (dh),
        .quo   (qy),
        .stat  (div_y_stat)
    );

    // clamp to the last source column and row
    assign sx     = (qx >= NUM_W'(sw)) ? POS_W'(sw - dim_t'(1)) : qx[POS_W-1:0];
    assign sy     = (qy >= NUM_W'(sh)) ? POS_W'(sh - dim_t'(1)) : qy[POS_W-1:0];
    assign prod_a = PROD_W'(sy) * PROD_W'(sw) + PROD_W'(sx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            if (load_fire)
                load_index_reg <= load_index_next;
            if (fetch_fire)
            begin
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_fire)
            last_reg <= col_end && row_end;
        if (state_reg == S_ADDR)
            addr_reg <= prod_a[ADDR_W-1:0];
    end

    // frame store: write on load, registered read for fetch
    always_ff @(posedge clk)
    begin
        if (load_fire)
            mem[load_index_reg] <= req.pixel_in;
        if (rd_en)
            rd_data_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pixel_out_next = pixel_out_reg;
        last_out_next  = last_out_reg;
        rd_en          = 1'b0;
        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fetch_fire)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_x_stat.done)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    pixel_out_next = rd_data_reg;
                    last_out_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
        last_out_reg  <= last_out_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.pixel_out  = pixel_out_reg;
    assign rsp.last_pixel = last_out_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_stat.done == div_y_stat.done)
        else $error("coordinate dividers out of step");

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_fire |-> ##DIV_LAT div_x_stat.done)
        else $error("divider did not finish on time");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_PUT)
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// testbench for the nearest neighbor scaler: predicts every fetched pixel and checks rsp
`timescale 1ns / 1ps

module tb_top;
    import nnis_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } scaled_pixel_t;

    // mirror of the scaler state plus the queue of pixels still owed on rsp
    class scaled_pixel_tracker;
        dim_t             size_reg [CFG_REGS];
        logic [PIX_W-1:0] store [FRAME_PIXELS];
        bit               loaded [FRAME_PIXELS];
        int unsigned      load_pos;
        int unsigned      col;
        int unsigned      row;
        scaled_pixel_t    pending [$];
        int unsigned      failures;
        int unsigned      reported;

        function new();
            foreach (size_reg[i])
                size_reg[i] = dim_t'(CFG_RESET);
            load_pos = 0;
            col      = 0;
            row      = 0;
            failures = 0;
            reported = 0;
        endfunction

        // register value as the block uses it: zero acts as one, large values saturate
        function int unsigned eff_size(input cfg_reg_t idx);
            int unsigned raw;
            raw = size_reg[idx];
            if (raw == 0)
                return 1;
            if (raw > DIM_MAX)
                return DIM_MAX;
            return raw;
        endfunction

        function int unsigned source_coord(input int unsigned pos, input int unsigned src_dim,
                                           input int unsigned dst_dim);
            int unsigned s;
            s = (pos * src_dim) / dst_dim;
            if (s >= src_dim)
                s = src_dim - 1;
            return s;
        endfunction

        function int unsigned fetch_addr();
            int unsigned sw;
            int unsigned sx;
            int unsigned sy;
            sw = eff_size(REG_SRC_WIDTH);
            sx = source_coord(col, sw, eff_size(REG_DST_WIDTH));
            sy = source_coord(row, eff_size(REG_SRC_HEIGHT), eff_size(REG_DST_HEIGHT));
            return (sy * sw + sx) % FRAME_PIXELS;
        endfunction

        function bit next_fetch_loaded();
            return loaded[fetch_addr()];
        endfunction

        function void note_config(input cfg_reg_t idx, input dim_t value);
            size_reg[idx] = value;
        endfunction

        function void note_request(input req_type_t kind, input logic [PIX_W-1:0] pix);
            int unsigned   nxt;
            bit            col_end;
            bit            row_end;
            scaled_pixel_t owed;
            if (kind == REQ_LOAD)
            begin
                store[load_pos]  = pix;
                loaded[load_pos] = 1'b1;
                nxt = load_pos + 1;
                // wraps at the frame size even when the frame shrank below the counter
                if (nxt >= eff_size(REG_SRC_WIDTH) * eff_size(REG_SRC_HEIGHT) ||
                    nxt >= FRAME_PIXELS)
                    nxt = 0;
                load_pos = nxt;
            end
            else
            begin
                col_end    = (col + 1) >= eff_size(REG_DST_WIDTH);
                row_end    = (row + 1) >= eff_size(REG_DST_HEIGHT);
                owed.pixel = store[fetch_addr()];
                owed.last  = col_end && row_end;
                pending.push_back(owed);
                if (col_end)
                begin
                    col = 0;
                    row = row_end ? 0 : row + 1;
                end
                else
                    col = col + 1;
            end
        endfunction

        function void check_pixel(input logic [PIX_W-1:0] pix, input logic last);
            scaled_pixel_t owed;
            if (pending.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                    $display("unexpected rsp transaction: pixel_out=%h last_pixel=%b", pix, last);
                reported++;
                return;
            end
            owed = pending.pop_front();
            if (pix !== owed.pixel || last !== owed.last)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                    $display("rsp mismatch: pixel_out exp %h got %h, last_pixel exp %b got %b",
                             owed.pixel, pix, owed.last, last);
                reported++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned idle_cycles = 0;
    int unsigned requests_sent;

    nnis_cfg_if cfg_ch ();
    nnis_req_if req_ch ();
    nnis_rsp_if rsp_ch ();

    scaled_pixel_tracker tracker = new();

    nearest_neighbor_image_scaler_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checking and the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_pixel(rsp_ch.pixel_out, rsp_ch.last_pixel);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(input req_type_t kind, input logic [PIX_W-1:0] pix);
        if (requests_sent >= 2 * RANDOM_ITEMS / 3)
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        else if (requests_sent >= RANDOM_ITEMS / 3)
        begin
            send_idle_pct  = 53;
            recv_stall_pct = 24;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.pixel_in <= pix;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        tracker.note_request(kind, pix);
        requests_sent++;
    endtask

    // never fetch from a store entry that was not loaded since reset
    task automatic fetch_or_fill();
        if (tracker.next_fetch_loaded())
            send_request(REQ_FETCH, $urandom());
        else
            send_request(REQ_LOAD, $urandom());
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        // a load is already written once accepted, so nothing is left in flight here
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input dim_t sw, input dim_t sh, input dim_t dw, input dim_t dh);
        dim_t     values [CFG_REGS];
        cfg_reg_t idx;
        values = '{sw, sh, dw, dh};
        wait_drained();
        for (int i = 0; i < CFG_REGS; i++)
        begin
            idx = cfg_reg_t'(i);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= values[i];
            do
                @(posedge clk);
            while (!(cfg_ch.valid && cfg_ch.ready));
            tracker.note_config(idx, values[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void pick_dims(output dim_t a, output dim_t b);
        case ($urandom_range(7))
            0:
            begin
                a = dim_t'($urandom_range(256, 511));
                b = dim_t'($urandom_range(1));
            end
            1:
            begin
                a = dim_t'($urandom_range(1));
                b = dim_t'($urandom_range(256, 511));
            end
            default:
            begin
                a = dim_t'($urandom_range(12));
                b = dim_t'($urandom_range(12));
            end
        endcase
    endfunction

    task automatic run_phase(input dim_t sw, input dim_t sh, input dim_t dw, input dim_t dh);
        int unsigned src_total;
        int unsigned dst_total;
        int unsigned fetches;
        write_sizes(sw, sh, dw, dh);
        src_total = tracker.eff_size(REG_SRC_WIDTH) * tracker.eff_size(REG_SRC_HEIGHT);
        dst_total = tracker.eff_size(REG_DST_WIDTH) * tracker.eff_size(REG_DST_HEIGHT);
        if (src_total <= 150 && $urandom_range(9) < 8)
        begin
            // whole source frame, then fetches for up to two output frames with stray loads
            repeat (src_total) send_request(REQ_LOAD, $urandom());
            fetches = $urandom_range(1) ? dst_total : $urandom_range(1, 2 * dst_total);
            repeat (fetches)
            begin
                if ($urandom_range(9) == 0)
                    send_request(REQ_LOAD, $urandom());
                fetch_or_fill();
            end
        end
        else
        begin
            repeat ($urandom_range(20, 80))
            begin
                if ($urandom_range(3) == 0)
                    send_request(REQ_LOAD, $urandom());
                else
                    fetch_or_fill();
            end
        end
    endtask

    initial
    begin
        dim_t sw;
        dim_t sh;
        dim_t dw;
        dim_t dh;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_LOAD;
        req_ch.pixel_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_SRC_WIDTH;
        cfg_ch.data     <= '0;
        send_idle_pct  = 24;
        recv_stall_pct = 53;
        requests_sent  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2 source, 3 wide output with a zero height
        write_sizes(dim_t'(2), dim_t'(2), dim_t'(3), dim_t'(0));
        send_request(REQ_LOAD, 32'h0000_0000);
        send_request(REQ_LOAD, 32'hFFFF_FFFF);
        send_request(REQ_LOAD, 32'hA5A5_A5A5);
        send_request(REQ_LOAD, 32'h5A5A_5A5A);
        // load counter has wrapped, overwrites the first pixel
        send_request(REQ_LOAD, 32'h8000_0001);
        repeat (5) fetch_or_fill();

        // source shrinks below the load counter, output narrower than the current column
        write_sizes(dim_t'(0), dim_t'(0), dim_t'(1), dim_t'(2));
        send_request(REQ_LOAD, 32'h1234_5678);
        repeat (4) fetch_or_fill();

        requests_sent = 0;
        run_phase(dim_t'(256), dim_t'(0), dim_t'(256), dim_t'(511));
        run_phase(dim_t'(1), dim_t'(256), dim_t'(0), dim_t'(256));
        while (requests_sent < RANDOM_ITEMS)
        begin
            pick_dims(sw, sh);
            pick_dims(dw, dh);
            run_phase(sw, sh, dw, dh);
        end

        wait_drained();
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/nnis_pkg.sv
rtl/nnis_if.sv
rtl/nnis_div.sv
rtl/nearest_neighbor_image_scaler_unit.sv
test/tb_top.sv
